>>> rtl/lgn_pkg.sv
// lgn_pkg: shared constants, widths and codes for the lattice gradient noise block.
// Depends on nothing; used by lgn_mul and lattice_gradient_noise in rtl/.
package lgn_pkg;

    localparam int GRAD_ENTRIES = 512;
    localparam int PERM_ENTRIES = 4096;
    localparam int MAX_OCTAVES  = 8;

    localparam int GRAD_AW = $clog2(GRAD_ENTRIES);
    localparam int PERM_AW = $clog2(PERM_ENTRIES);
    localparam int CELL_W  = 12;
    localparam int LVL_W   = $clog2(MAX_OCTAVES + 1);

    // shared multiplier operand and product widths
    localparam int MUL_A_W = 35;
    localparam int MUL_B_W = 19;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    localparam int ACC_W  = 56;  // exact Q47 corner sum
    localparam int GSUM_W = 26;  // octave sum of gradient components

    typedef enum logic [2:0] {
        OP_LOAD_HASH = 3'd0,
        OP_LOAD_GRAD = 3'd1,
        OP_NOISE     = 3'd2,
        OP_GRAD      = 3'd3,
        OP_TURB      = 3'd4,
        OP_GRAD_TURB = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        CFG_OFFSET_X = 2'd0,
        CFG_OFFSET_Y = 2'd1,
        CFG_OFFSET_Z = 2'd2
    } cfg_idx_t;

endpackage

>>> rtl/lgn_ram.sv
// lgn_ram: generic single-write, single-read memory with registered read data.
// Depends on nothing.
module lgn_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 12
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/lgn_mul.sv
// lgn_mul: the shared signed multiplier, product registered.
// Depends on lgn_pkg for operand widths.
module lgn_mul (
    input  logic                               aclk,
    input  logic signed [lgn_pkg::MUL_A_W-1:0] a,
    input  logic signed [lgn_pkg::MUL_B_W-1:0] b,
    output logic signed [lgn_pkg::MUL_P_W-1:0] p
);

    logic signed [lgn_pkg::MUL_P_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= a * b;
    end

    assign p = prod_reg;

endmodule

>>> rtl/lattice_gradient_noise.sv
// lattice_gradient_noise: 3D lattice gradient noise with turbulence, one shared multiplier.
// Table loads are written as they are accepted and leave the sequencer idle. Sample time is set
//   by the single multiplier and the chained perm reads; each octave runs one gradient pass per corner
//   for scalar noise and three for gradients, and a request runs its octaves in turn.
// Throughput: one request at a time; the next is taken while a result waits at the output.
// Reset (aresetn, synchronous, active low): sequencer idle, no result pending, offsets 0.
//   Perm and gradient tables are not cleared and must be loaded before sampling.
module lattice_gradient_noise (
    input  logic                aclk,
    input  logic                aresetn,
    // configuration
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    // request channel
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [2:0]          s_op,
    input  logic signed [31:0]  s_coord_x,
    input  logic signed [31:0]  s_coord_y,
    input  logic signed [31:0]  s_coord_z,
    input  logic [3:0]          s_octave_count,
    input  logic [11:0]         s_table_index,
    input  logic signed [15:0]  s_table_value,
    // result channel
    output logic                m_valid,
    input  logic                m_ready,
    output logic [17:0]         m_noise_value,
    output logic signed [20:0]  m_grad_x,
    output logic signed [20:0]  m_grad_y,
    output logic signed [20:0]  m_grad_z
);

    localparam int GAW = lgn_pkg::GRAD_AW;
    localparam int PAW = lgn_pkg::PERM_AW;
    localparam int LW  = lgn_pkg::LVL_W;
    localparam int AW  = lgn_pkg::ACC_W;
    localparam int GW  = lgn_pkg::GSUM_W;
    localparam int MA  = lgn_pkg::MUL_A_W;
    localparam int MB  = lgn_pkg::MUL_B_W;
    localparam int MP  = lgn_pkg::MUL_P_W;

    // Sequencer: per octave SETUP, three smoothing passes (SM_*), then per corner a
    // three-deep perm chain (H*) overlapped with the weight product, then per gradient
    // component four table reads and products (GA/GM/GS), the weighting (GW) and accumulate.
    typedef enum logic [15:0] {
        ST_IDLE  = 16'h0001,
        ST_SETUP = 16'h0002,
        ST_SM_A  = 16'h0004,
        ST_SM_B  = 16'h0008,
        ST_SM_C  = 16'h0010,
        ST_H0    = 16'h0020,
        ST_H1    = 16'h0040,
        ST_H2    = 16'h0080,
        ST_H3    = 16'h0100,
        ST_GA    = 16'h0200,
        ST_GM    = 16'h0400,
        ST_GS    = 16'h0800,
        ST_GW    = 16'h1000,
        ST_GACC  = 16'h2000,
        ST_FIN   = 16'h4000,
        ST_DONE  = 16'h8000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [31:0] off_reg [3];

    // request registers
    logic [31:0]         crd_reg [3];
    logic                is_grad_reg;
    logic [LW-1:0]       levels_reg;
    logic [LW-1:0]       oct_reg;

    // per-octave lattice state
    logic [11:0]         cell_reg [3];
    logic [15:0]         frac_reg [3];
    logic [15:0]         smooth_reg [3];
    logic [1:0]          axis_reg;
    logic [2:0]          corner_reg;
    logic [1:0]          comp_reg;
    logic [1:0]          tap_reg;
    logic [7:0]          hash_reg;
    logic [16:0]         weight_reg;
    logic signed [MA-1:0] inner_reg;
    logic signed [AW-1:0] acc_reg [3];

    // results
    logic [17:0]          nv_reg;
    logic signed [GW-1:0] gsum_reg [3];
    logic                 m_valid_reg;
    logic [17:0]          out_nv_reg;
    logic signed [20:0]   out_g_reg [3];

    // shared unit and memories
    logic signed [MA-1:0] mul_a;
    logic signed [MB-1:0] mul_b;
    logic signed [MP-1:0] mul_p;

    logic            perm_we;
    logic [PAW-1:0]  perm_raddr;
    logic [11:0]     perm_rdata;
    logic            grad_we;
    logic [GAW-1:0]  grad_raddr;
    logic [15:0]     grad_rdata;

    logic            accept;
    logic            out_free;
    logic [2:0]      last_comp;

    // corner decode
    logic            bx, by, bz;
    logic [11:0]     ix, iy, iz;
    logic [16:0]     wx, wy, wz;
    logic [GAW-1:0]  grad_base;
    logic signed [MB-1:0] dsel;

    // octave close-out
    logic signed [AW-32:0] nsh;
    logic signed [AW-31:0] nfull;
    logic [16:0]           nclamp;
    logic [16:0]           nscaled;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    assign perm_we  = accept && (s_op == lgn_pkg::OP_LOAD_HASH);
    assign grad_we  = accept && (s_op == lgn_pkg::OP_LOAD_GRAD)
                      && ({1'b0, s_table_index} < 13'(lgn_pkg::GRAD_ENTRIES));

    lgn_ram #(.DEPTH(lgn_pkg::PERM_ENTRIES), .WIDTH(12)) u_perm (
        .aclk  (aclk),
        .we    (perm_we),
        .waddr (s_table_index[PAW-1:0]),
        .wdata (s_table_value[11:0]),
        .raddr (perm_raddr),
        .rdata (perm_rdata)
    );

    lgn_ram #(.DEPTH(lgn_pkg::GRAD_ENTRIES), .WIDTH(16)) u_grad (
        .aclk  (aclk),
        .we    (grad_we),
        .waddr (s_table_index[GAW-1:0]),
        .wdata (s_table_value),
        .raddr (grad_raddr),
        .rdata (grad_rdata)
    );

    lgn_mul u_mul (
        .aclk (aclk),
        .a    (mul_a),
        .b    (mul_b),
        .p    (mul_p)
    );

    // Corner k: bit 0 picks x+1, bit 1 y+1, bit 2 z+1.
    always_comb begin
        bx = corner_reg[0];
        by = corner_reg[1];
        bz = corner_reg[2];
        ix = cell_reg[0] + {11'd0, bx};
        iy = cell_reg[1] + {11'd0, by};
        iz = cell_reg[2] + {11'd0, bz};
        wx = bx ? {1'b0, smooth_reg[0]} : 17'h10000 - {1'b0, smooth_reg[0]};
        wy = by ? {1'b0, smooth_reg[1]} : 17'h10000 - {1'b0, smooth_reg[1]};
        wz = bz ? {1'b0, smooth_reg[2]} : 17'h10000 - {1'b0, smooth_reg[2]};
        grad_base = GAW'(hash_reg) + GAW'({comp_reg, 2'b00});
        case (tap_reg)
            2'd0:    dsel = MB'(32768);
            2'd1:    dsel = $signed({3'b000, frac_reg[0]}) - (bx ? MB'(65536) : MB'(0));
            2'd2:    dsel = $signed({3'b000, frac_reg[1]}) - (by ? MB'(65536) : MB'(0));
            default: dsel = $signed({3'b000, frac_reg[2]}) - (bz ? MB'(65536) : MB'(0));
        endcase
        last_comp = is_grad_reg ? 3'd2 : 3'd0;
    end

    // Scalar noise of this octave: floor(sum/2^31) + 0.5, clamped, scaled by 2^-octave.
    always_comb begin
        nsh   = acc_reg[0][AW-1:31];
        nfull = $signed({nsh[AW-32], nsh}) + (AW-30)'(32768);
        if (nfull < 0) begin
            nclamp = 17'd0;
        end else if (nfull > (AW-30)'(65536)) begin
            nclamp = 17'h10000;
        end else begin
            nclamp = nfull[16:0];
        end
        nscaled = nclamp >> oct_reg;
    end

    // Multiplier operands and memory read addresses per state.
    always_comb begin
        mul_a      = '0;
        mul_b      = '0;
        perm_raddr = ix;
        grad_raddr = grad_base + GAW'(tap_reg) + GAW'(1);
        case (state_reg)
            ST_SM_A: begin
                mul_a = MA'({1'b0, frac_reg[axis_reg]});
                mul_b = MB'({1'b0, frac_reg[axis_reg]});
            end
            ST_SM_B: begin
                mul_a = MA'({1'b0, mul_p[31:0]});
                mul_b = MB'(196608) - MB'({frac_reg[axis_reg], 1'b0});
            end
            ST_H0: begin
                perm_raddr = ix;
                mul_a      = MA'(wx);
                mul_b      = MB'(wy);
            end
            ST_H1: begin
                perm_raddr = perm_rdata ^ iy;
                mul_a      = MA'(mul_p[33:16]);
                mul_b      = MB'(wz);
            end
            ST_H2: begin
                perm_raddr = perm_rdata ^ iz;
            end
            ST_GA: begin
                grad_raddr = grad_base;
            end
            ST_GM: begin
                // gradient entries are signed Q1.15
                mul_a = MA'($signed(grad_rdata));
                mul_b = dsel;
            end
            ST_GW: begin
                mul_a = inner_reg;
                mul_b = MB'({1'b0, weight_reg});
            end
            default: begin
                mul_a = '0;
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (s_op)
                        lgn_pkg::OP_NOISE, lgn_pkg::OP_GRAD: state_next = ST_SETUP;
                        lgn_pkg::OP_TURB, lgn_pkg::OP_GRAD_TURB: begin
                            state_next = (s_octave_count == 4'd0) ? ST_DONE : ST_SETUP;
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SETUP: state_next = ST_SM_A;
            ST_SM_A:  state_next = ST_SM_B;
            ST_SM_B:  state_next = ST_SM_C;
            ST_SM_C:  state_next = (axis_reg == 2'd2) ? ST_H0 : ST_SM_A;
            ST_H0:    state_next = ST_H1;
            ST_H1:    state_next = ST_H2;
            ST_H2:    state_next = ST_H3;
            ST_H3:    state_next = ST_GA;
            ST_GA:    state_next = ST_GM;
            ST_GM:    state_next = ST_GS;
            ST_GS:    state_next = (tap_reg == 2'd3) ? ST_GW : ST_GM;
            ST_GW:    state_next = ST_GACC;
            ST_GACC: begin
                if ({1'b0, comp_reg} != last_comp) begin
                    state_next = ST_GA;
                end else if (corner_reg == 3'd7) begin
                    state_next = ST_FIN;
                end else begin
                    state_next = ST_H0;
                end
            end
            ST_FIN:   state_next = (oct_reg + LW'(1) == levels_reg) ? ST_DONE : ST_SETUP;
            ST_DONE:  state_next = out_free ? ST_IDLE : ST_DONE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            off_reg[0]  <= '0;
            off_reg[1]  <= '0;
            off_reg[2]  <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                case (cfg_index)
                    lgn_pkg::CFG_OFFSET_X: off_reg[0] <= cfg_data;
                    lgn_pkg::CFG_OFFSET_Y: off_reg[1] <= cfg_data;
                    lgn_pkg::CFG_OFFSET_Z: off_reg[2] <= cfg_data;
                    default: ;
                endcase
            end
            if (state_reg == ST_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers (no reset needed).
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                crd_reg[0]  <= s_coord_x;
                crd_reg[1]  <= s_coord_y;
                crd_reg[2]  <= s_coord_z;
                is_grad_reg <= (s_op == lgn_pkg::OP_GRAD) || (s_op == lgn_pkg::OP_GRAD_TURB);
                if ((s_op == lgn_pkg::OP_NOISE) || (s_op == lgn_pkg::OP_GRAD)) begin
                    levels_reg <= LW'(1);
                end else if ({1'b0, s_octave_count} > 5'(lgn_pkg::MAX_OCTAVES)) begin
                    levels_reg <= LW'(lgn_pkg::MAX_OCTAVES);
                end else begin
                    levels_reg <= LW'(s_octave_count);
                end
                oct_reg     <= '0;
                nv_reg      <= '0;
                gsum_reg[0] <= '0;
                gsum_reg[1] <= '0;
                gsum_reg[2] <= '0;
            end
            ST_SETUP: begin
                // p = coord * 2^octave - offset, modulo 2^32
                for (int a = 0; a < 3; a++) begin
                    cell_reg[a] <= 12'(((crd_reg[a] << oct_reg) - off_reg[a]) >> 16);
                    frac_reg[a] <= 16'((crd_reg[a] << oct_reg) - off_reg[a]);
                    acc_reg[a]  <= '0;
                end
                axis_reg   <= '0;
                corner_reg <= '0;
            end
            ST_SM_C: begin
                // s = f*f*(3 - 2f), bits 47:32 of the Q48 product
                smooth_reg[axis_reg] <= mul_p[47:32];
                axis_reg             <= axis_reg + 2'd1;
            end
            ST_H2: begin
                weight_reg <= mul_p[32:16];
            end
            ST_H3: begin
                hash_reg <= perm_rdata[7:0];
                comp_reg <= '0;
            end
            ST_GA: begin
                tap_reg   <= '0;
                inner_reg <= '0;
            end
            ST_GS: begin
                inner_reg <= inner_reg + mul_p[MA-1:0];
                tap_reg   <= tap_reg + 2'd1;
            end
            ST_GACC: begin
                acc_reg[comp_reg] <= acc_reg[comp_reg] + AW'(mul_p);
                if ({1'b0, comp_reg} == last_comp) begin
                    corner_reg <= corner_reg + 3'd1;
                    comp_reg   <= '0;
                end else begin
                    comp_reg <= comp_reg + 2'd1;
                end
            end
            ST_FIN: begin
                if (is_grad_reg) begin
                    for (int c = 0; c < 3; c++) begin
                        gsum_reg[c] <= gsum_reg[c]
                                       + GW'(acc_reg[c] >>> (6'd31 + 6'(oct_reg)));
                    end
                end else begin
                    nv_reg <= nv_reg + {1'b0, nscaled};
                end
                oct_reg <= oct_reg + LW'(1);
            end
            ST_DONE: begin
                if (out_free) begin
                    out_nv_reg <= nv_reg;
                    for (int c = 0; c < 3; c++) begin
                        if (gsum_reg[c] > GW'(1048575)) begin
                            out_g_reg[c] <= 21'sd1048575;
                        end else if (gsum_reg[c] < -GW'(1048576)) begin
                            out_g_reg[c] <= -21'sd1048576;
                        end else begin
                            out_g_reg[c] <= gsum_reg[c][20:0];
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    assign m_valid       = m_valid_reg;
    assign m_noise_value = out_nv_reg;
    assign m_grad_x      = out_g_reg[0];
    assign m_grad_y      = out_g_reg[1];
    assign m_grad_z      = out_g_reg[2];

endmodule
